/* hw/rtl/ber_pkg.sv */
// ----------------------------------------------------------------------------
// ber_pkg
// shared types and constants for the box edge rounding pipeline
// ----------------------------------------------------------------------------
package ber_pkg;

    localparam int RADIUS_BITS = 14;

    typedef struct packed {
        logic valid;
        logic stall;
    } ber_ctrl_t;

endpackage

/* hw/rtl/ber_pass.sv */
// ----------------------------------------------------------------------------
// ber_pass
// one plane pass: quadrant test, pipelined square root and two dividers
// advances only when adv is high
// ----------------------------------------------------------------------------
module ber_pass #(
    parameter int CB = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic                             vin,
    input  logic [ber_pkg::RADIUS_BITS-1:0]  radius,
    input  logic signed [CB-1:0]             a_in,
    input  logic signed [CB-1:0]             b_in,
    input  logic signed [CB-1:0]             k_in,
    output logic                             vout,
    output logic signed [CB-1:0]             a_out,
    output logic signed [CB-1:0]             b_out,
    output logic signed [CB-1:0]             k_out
);
    import ber_pkg::*;

    localparam int FB = CB - 2;
    localparam int MB = CB + 1;
    localparam int SB = 2 * MB + 2;
    localparam int SQ = SB / 2;
    localparam int NB = MB + FB;
    localparam int DV = NB;
    localparam int LAT = 2 + SQ + 1 + DV + 1;
    localparam int RW = (FB < RADIUS_BITS) ? FB : RADIUS_BITS;

    typedef struct packed {
        logic              act;
        logic              sa;
        logic              sb;
        logic [MB-1:0]     ma;
        logic [MB-1:0]     mb;
        logic signed [CB:0] ca;
        logic signed [CB:0] cb;
        logic signed [CB-1:0] a;
        logic signed [CB-1:0] b;
        logic signed [CB-1:0] k;
        logic [FB-1:0]     r;
    } item_t;

    logic [LAT-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[LAT-2:0], vin};
        end
    end

    // front stage
    logic [FB-1:0] r_w;
    logic signed [CB+1:0] c_w, a_w, b_w;
    logic signed [CB+1:0] da_w, db_w;
    logic sa_gt, sa_lt, sb_gt, sb_lt;
    item_t f_w, f_reg;

    assign r_w = FB'(radius[RW-1:0]);

    always_comb
    begin
        c_w = (CB+2)'(1 << FB) - (CB+2)'(r_w);
        a_w = (CB+2)'(a_in);
        b_w = (CB+2)'(b_in);
        sa_gt = a_w > c_w;
        sa_lt = a_w < -c_w;
        sb_gt = b_w > c_w;
        sb_lt = b_w < -c_w;
        da_w = sa_gt ? a_w - c_w : -c_w - a_w;
        db_w = sb_gt ? b_w - c_w : -c_w - b_w;
        f_w.act = (sa_gt || sa_lt) && (sb_gt || sb_lt);
        f_w.sa = sa_gt;
        f_w.sb = sb_gt;
        f_w.ma = da_w[MB-1:0];
        f_w.mb = db_w[MB-1:0];
        f_w.ca = sa_gt ? c_w[CB:0] : -c_w[CB:0];
        f_w.cb = sb_gt ? c_w[CB:0] : -c_w[CB:0];
        f_w.a = a_in;
        f_w.b = b_in;
        f_w.k = k_in;
        f_w.r = r_w;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_reg <= f_w;
        end
    end

    // squared length
    item_t p_reg;
    logic [SB-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg <= f_reg;
            sum_reg <= SB'(f_reg.ma) * SB'(f_reg.ma) + SB'(f_reg.mb) * SB'(f_reg.mb);
        end
    end

    // square root, one result bit per stage
    item_t sq_it_reg [SQ];
    logic [SB-1:0] sq_rem_reg [SQ];
    logic [SQ-1:0] sq_res_reg [SQ];

    genvar gi;
    generate
        for (gi = 0; gi < SQ; gi++)
        begin : g_sq
            logic [SB-1:0] rem_i;
            logic [SQ-1:0] res_i;
            item_t it_i;
            if (gi == 0)
            begin : g_first
                assign rem_i = sum_reg;
                assign res_i = '0;
                assign it_i = p_reg;
            end
            else
            begin : g_next
                assign rem_i = sq_rem_reg[gi-1];
                assign res_i = sq_res_reg[gi-1];
                assign it_i = sq_it_reg[gi-1];
            end
            localparam int SH = 2 * (SQ - 1 - gi);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_it_reg[gi] <= it_i;
                    if (rem_i >= ((SB'(res_i) << (SH + 2)) | (SB'(1) << SH)))
                    begin
                        sq_rem_reg[gi] <= rem_i - ((SB'(res_i) << (SH + 2)) | (SB'(1) << SH));
                        sq_res_reg[gi] <= {res_i[SQ-2:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_reg[gi] <= rem_i;
                        sq_res_reg[gi] <= {res_i[SQ-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // prepare division
    item_t dp_w;
    item_t dp_it_reg;
    logic [SQ-1:0] len_reg;
    logic [NB-1:0] na_reg, nb_reg;

    always_comb
    begin
        dp_w = sq_it_reg[SQ-1];
        dp_w.act = sq_it_reg[SQ-1].act
            && (sq_res_reg[SQ-1] > SQ'(sq_it_reg[SQ-1].r));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dp_it_reg <= dp_w;
            len_reg <= sq_res_reg[SQ-1];
            na_reg <= NB'(sq_it_reg[SQ-1].ma) * NB'(sq_it_reg[SQ-1].r);
            nb_reg <= NB'(sq_it_reg[SQ-1].mb) * NB'(sq_it_reg[SQ-1].r);
        end
    end

    // restoring dividers, one quotient bit per stage
    item_t dv_it_reg [DV];
    logic [SQ-1:0] dv_len_reg [DV];
    logic [NB-1:0] qa_reg [DV], qb_reg [DV];
    logic [SQ:0] ra_reg [DV], rb_reg [DV];

    generate
        for (gi = 0; gi < DV; gi++)
        begin : g_dv
            item_t it_i;
            logic [SQ-1:0] l_i;
            logic [NB-1:0] qa_i, qb_i;
            logic [SQ:0] ra_i, rb_i;
            logic [SQ+1:0] ta, tb;
            if (gi == 0)
            begin : g_first
                assign it_i = dp_it_reg;
                assign l_i = len_reg;
                assign qa_i = na_reg;
                assign qb_i = nb_reg;
                assign ra_i = '0;
                assign rb_i = '0;
            end
            else
            begin : g_next
                assign it_i = dv_it_reg[gi-1];
                assign l_i = dv_len_reg[gi-1];
                assign qa_i = qa_reg[gi-1];
                assign qb_i = qb_reg[gi-1];
                assign ra_i = ra_reg[gi-1];
                assign rb_i = rb_reg[gi-1];
            end
            assign ta = {ra_i, qa_i[NB-1]};
            assign tb = {rb_i, qb_i[NB-1]};
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_it_reg[gi] <= it_i;
                    dv_len_reg[gi] <= l_i;
                    if (ta >= (SQ+2)'(l_i))
                    begin
                        ra_reg[gi] <= (SQ+1)'(ta - (SQ+2)'(l_i));
                        qa_reg[gi] <= {qa_i[NB-2:0], 1'b1};
                    end
                    else
                    begin
                        ra_reg[gi] <= ta[SQ:0];
                        qa_reg[gi] <= {qa_i[NB-2:0], 1'b0};
                    end
                    if (tb >= (SQ+2)'(l_i))
                    begin
                        rb_reg[gi] <= (SQ+1)'(tb - (SQ+2)'(l_i));
                        qb_reg[gi] <= {qb_i[NB-2:0], 1'b1};
                    end
                    else
                    begin
                        rb_reg[gi] <= tb[SQ:0];
                        qb_reg[gi] <= {qb_i[NB-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // output stage
    item_t o_it;
    logic signed [CB+1:0] ra_w, rb_w;
    logic signed [CB-1:0] a_reg, b_reg, k_reg;

    always_comb
    begin
        o_it = dv_it_reg[DV-1];
        ra_w = o_it.sa ? (CB+2)'(o_it.ca) + (CB+2)'(qa_reg[DV-1][MB-1:0])
                       : (CB+2)'(o_it.ca) - (CB+2)'(qa_reg[DV-1][MB-1:0]);
        rb_w = o_it.sb ? (CB+2)'(o_it.cb) + (CB+2)'(qb_reg[DV-1][MB-1:0])
                       : (CB+2)'(o_it.cb) - (CB+2)'(qb_reg[DV-1][MB-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= o_it.act ? ra_w[CB-1:0] : o_it.a;
            b_reg <= o_it.act ? rb_w[CB-1:0] : o_it.b;
            k_reg <= o_it.k;
        end
    end

    assign vout = v_reg[LAT-1];
    assign a_out = a_reg;
    assign b_out = b_reg;
    assign k_out = k_reg;

endmodule

/* hw/rtl/box_edge_rounding_core.sv */
// ----------------------------------------------------------------------------
// box_edge_rounding_core
// rounds box edges of a vertex stream to a configured corner radius
// ----------------------------------------------------------------------------
// Accepts one vertex per cycle while the pipe is not stalled. The three plane
// passes feed an output register; each pass runs a quadrant test, a squared
// length stage, a one-bit-per-stage square root, a product stage, two
// one-bit-per-stage dividers and a result stage. The whole pipe stalls
// when the output register is full and not taken.
module box_edge_rounding_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ber_pkg::RADIUS_BITS-1:0]    cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // x_in, y_in, z_in
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // x_out, y_out, z_out
    output logic [((3*COORD_BITS+7)/8)*8-1:0]  m_axis_tdata
);
    import ber_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DW = ((3*CB+7)/8)*8;

    logic [RADIUS_BITS-1:0] radius_reg;
    ber_ctrl_t ctl;
    logic v1, v2, v3;
    logic signed [CB-1:0] x1, y1, z1, z2, y2, x2, x3, z3, y3;
    logic ov_reg;
    logic [DW-1:0] od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_BITS'(1638);
        end
        else if (cfg_we)
        begin
            radius_reg <= cfg_wdata;
        end
    end

    assign ctl.stall = ov_reg && !m_axis_tready;
    assign ctl.valid = s_axis_tvalid && !ctl.stall;
    assign s_axis_tready = !ctl.stall;

    ber_pass #(.CB(CB)) u_xy (
        .clk(clk), .rst_n(rst_n), .adv(!ctl.stall), .vin(ctl.valid), .radius(radius_reg),
        .a_in(s_axis_tdata[CB-1:0]), .b_in(s_axis_tdata[2*CB-1:CB]),
        .k_in(s_axis_tdata[3*CB-1:2*CB]),
        .vout(v1), .a_out(x1), .b_out(y1), .k_out(z1)
    );

    ber_pass #(.CB(CB)) u_zy (
        .clk(clk), .rst_n(rst_n), .adv(!ctl.stall), .vin(v1), .radius(radius_reg),
        .a_in(z1), .b_in(y1), .k_in(x1),
        .vout(v2), .a_out(z2), .b_out(y2), .k_out(x2)
    );

    ber_pass #(.CB(CB)) u_xz (
        .clk(clk), .rst_n(rst_n), .adv(!ctl.stall), .vin(v2), .radius(radius_reg),
        .a_in(x2), .b_in(z2), .k_in(y2),
        .vout(v3), .a_out(x3), .b_out(z3), .k_out(y3)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (!ctl.stall)
        begin
            ov_reg <= v3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.stall)
        begin
            od_reg <= DW'({z3, y3, x3});
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = od_reg;

endmodule

/* hw/rtl/ber_checker.sv */
// ----------------------------------------------------------------------------
// ber_checker
// port-level checks for the box edge rounding core
// ----------------------------------------------------------------------------
module ber_checker #(
    parameter int DW = 48
) (
    input logic          clk,
    input logic          rst_n,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [DW-1:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == !(m_axis_tvalid && !m_axis_tready))
        else $error("ready does not follow output stall");

    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("stall with empty output");

endmodule

bind box_edge_rounding_core ber_checker #(.DW(DW)) u_ber_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
